// ----- rtl/core/raster_to_bgra32_converter_defines.svh -----
// assertion macros shared by the converter rtl
`ifndef RASTER_TO_BGRA32_CONVERTER_DEFINES_SVH
`define RASTER_TO_BGRA32_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RTB_ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RTB_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rtb_pkg.sv -----
// shared types and constants for the raster to bgra32 converter
`timescale 1ns / 1ps
package rtb_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;
  localparam int         NIBBLE_SHIFT = 4;

  // source formats
  localparam logic [2:0] FMT_BGRA32 = 3'd0;
  localparam logic [2:0] FMT_RGBA32 = 3'd1;
  localparam logic [2:0] FMT_BGR32  = 3'd2;
  localparam logic [2:0] FMT_RGB32  = 3'd3;
  localparam logic [2:0] FMT_PAL4   = 3'd4;
  localparam logic [2:0] FMT_PAL8   = 3'd5;
  localparam logic [2:0] FMT_BGR24  = 3'd6;
  localparam logic [2:0] FMT_RGB24  = 3'd7;

  // input transaction kinds
  localparam logic ACT_PAL_WRITE = 1'b0;
  localparam logic ACT_RASTER    = 1'b1;

  // register indexes
  localparam logic REG_SOURCE_FORMAT = 1'b0;

  // operations passed from front to back
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_PAL8  = 2'd2;
  localparam logic [1:0] OP_PAL4  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [31:0] data;
    logic        last;
  } rtb_op_t;

  // palette word r,g,b,a -> b,g,r,a
  function automatic logic [31:0] pal_to_bgra(input logic [31:0] w);
    pal_to_bgra = {w[31:24], w[7:0], w[15:8], w[23:16]};
  endfunction

endpackage

// ----- rtl/core/rtb_ram.sv -----
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
module rtb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/rtb_front.sv -----
// front end: takes input transactions, gathers bytes and issues operations
`timescale 1ns / 1ps
module rtb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic            action,
  input  logic [7:0]      palette_index,
  input  logic [31:0]     palette_entry,
  input  logic [7:0]      raster_byte,
  input  logic            last_byte,
  input  logic [2:0]      source_format,
  input  logic            format_write,
  output logic            push,
  output rtb_pkg::rtb_op_t push_op
);
  import rtb_pkg::*;

  logic [23:0] byte_gather;
  logic [23:0] byte_gather_next;
  logic [1:0]  byte_position;
  logic [1:0]  byte_position_next;
  logic        accept;
  logic        is_24;
  logic        complete;
  logic        swap_rb;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  alpha;
  logic [23:0] shifted;

  assign accept  = in_valid && in_ready;
  assign is_24   = (source_format == FMT_BGR24) || (source_format == FMT_RGB24);
  // the incoming byte closes the pixel
  assign complete = is_24 ? (byte_position == 2'd2) : (byte_position == 2'd3);
  assign swap_rb = (source_format == FMT_RGBA32) || (source_format == FMT_RGB32) ||
                   (source_format == FMT_RGB24);
  assign shifted = {16'd0, raster_byte} << {byte_position, 3'b000};

  always_comb begin
    b0    = byte_gather[7:0];
    b1    = byte_gather[15:8];
    b2    = is_24 ? raster_byte : byte_gather[23:16];
    alpha = is_24 ? ALPHA_OPAQUE : raster_byte;
  end

  always_comb begin
    push               = 1'b0;
    push_op.kind       = OP_WRITE;
    push_op.index      = palette_index;
    push_op.data       = palette_entry;
    push_op.last       = last_byte;
    byte_gather_next   = byte_gather;
    byte_position_next = byte_position;
    if (accept) begin
      if (action == ACT_PAL_WRITE) begin
        push = 1'b1;
      end else begin
        case (source_format)
          FMT_PAL4: begin
            push          = 1'b1;
            push_op.kind  = OP_PAL4;
            push_op.index = raster_byte;
            if (last_byte) begin
              byte_gather_next   = '0;
              byte_position_next = '0;
            end
          end
          FMT_PAL8: begin
            push          = 1'b1;
            push_op.kind  = OP_PAL8;
            push_op.index = raster_byte;
            if (last_byte) begin
              byte_gather_next   = '0;
              byte_position_next = '0;
            end
          end
          default: begin
            if (complete) begin
              push               = 1'b1;
              push_op.kind       = OP_PIXEL;
              push_op.data       = swap_rb ? {alpha, b0, b1, b2} : {alpha, b2, b1, b0};
              byte_gather_next   = '0;
              byte_position_next = '0;
            end else if (last_byte) begin
              // partial pixel at end of image is dropped
              byte_gather_next   = '0;
              byte_position_next = '0;
            end else begin
              byte_gather_next   = byte_gather | shifted;
              byte_position_next = byte_position + 2'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || format_write) begin
      byte_gather   <= '0;
      byte_position <= '0;
    end else begin
      byte_gather   <= byte_gather_next;
      byte_position <= byte_position_next;
    end
  end

endmodule

// ----- rtl/core/rtb_queue.sv -----
// short operation queue between front and back
`timescale 1ns / 1ps
module rtb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rtb_pkg::rtb_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output rtb_pkg::rtb_op_t head_op
);
  import rtb_pkg::*;
  `include "raster_to_bgra32_converter_defines.svh"

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  rtb_op_t         entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(do_push) - CntW'(do_pop);
    end
  end

  `RTB_ASSERT_IMPLIES(a_push_not_full, clk, rst, push, !full, "push into full queue")
  `RTB_ASSERT_IMPLIES(a_pop_not_empty, clk, rst, pop, head_valid, "pop from empty queue")
  `RTB_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CntW'(QUEUE_DEPTH), "queue count overflow")

endmodule

// ----- rtl/core/rtb_back.sv -----
// back end: palette writes and lookups, result stage
`timescale 1ns / 1ps
module rtb_back #(
  parameter int PaletteDepth = rtb_pkg::PALETTE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  rtb_pkg::rtb_op_t head_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_pixel,
  output logic             out_last
);
  import rtb_pkg::*;
  `include "raster_to_bgra32_converter_defines.svh"

  localparam int AddrW = $clog2(PaletteDepth);

  logic             advance;
  logic             half;
  logic             half_next;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       look_idx;
  logic             look_last;
  logic             load;
  logic             in_range_w;
  logic             in_range_r;
  logic [31:0]      ram_rdata;
  logic             b_valid;
  logic             b_lookup;
  logic             b_zero;
  logic [31:0]      b_pixel;
  logic             b_last;

  assign advance    = !b_valid || out_ready;
  assign in_range_w = {1'b0, head_op.index} < 9'(PaletteDepth);
  assign in_range_r = {1'b0, look_idx} < 9'(PaletteDepth);

  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load      = 1'b0;
    half_next = half;
    look_idx  = head_op.index;
    look_last = head_op.last;
    if (head_valid) begin
      case (head_op.kind)
        OP_WRITE: begin
          // writes bypass the result stage
          pop    = 1'b1;
          ram_we = in_range_w;
        end
        OP_PIXEL: begin
          pop  = advance;
          load = advance;
        end
        OP_PAL8: begin
          pop    = advance;
          load   = advance;
          ram_re = advance;
        end
        OP_PAL4: begin
          // high nibble first, then low nibble
          look_idx  = half ? {4'd0, head_op.index[3:0] & NIBBLE_MASK}
                           : {4'd0, head_op.index[7:NIBBLE_SHIFT]};
          look_last = half && head_op.last;
          pop       = advance && half;
          load      = advance;
          ram_re    = advance;
          if (advance) begin
            half_next = !half;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  rtb_ram #(
    .Width(32),
    .Depth(PaletteDepth)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head_op.index[AddrW-1:0]),
    .wdata(head_op.data),
    .re   (ram_re),
    .raddr(look_idx[AddrW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      half    <= 1'b0;
    end else begin
      half <= half_next;
      if (advance) begin
        b_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_lookup <= (head_op.kind != OP_PIXEL);
      b_zero   <= !in_range_r;
      b_pixel  <= head_op.data;
      b_last   <= look_last;
    end
  end

  assign out_valid = b_valid;
  assign out_last  = b_last;
  assign out_pixel = !b_lookup ? b_pixel : (b_zero ? 32'd0 : pal_to_bgra(ram_rdata));

  `RTB_ASSERT_IMPLIES(a_read_on_advance, clk, rst, ram_re, advance, "palette read while stalled")
  `RTB_ASSERT_IMPLIES(a_rw_exclusive, clk, rst, ram_we, !ram_re, "palette read and write together")
  `RTB_ASSERT_IMPLIES(a_half_in_pal4, clk, rst, half, head_valid && head_op.kind == OP_PAL4, "second nibble without pal4 op")
  `RTB_ASSERT_NEXT(a_pal4_first_not_last, clk, rst, advance && head_valid && head_op.kind == OP_PAL4 && !half, b_valid && !b_last, "first pal4 pixel marked last")

endmodule

// ----- rtl/core/raster_to_bgra32_converter.sv -----
// raster to bgra32 converter top level
// Usage:
//   s_* stream takes one transaction per cycle while the queue has room. s_tuser is the action:
//   0 writes palette entry s_tdata[39:8] at index s_tdata[7:0], 1 delivers
//   raster byte s_tdata[47:40] with s_tlast marking the last byte of an image.
//   m_* stream gives bgra32 pixels in m_tdata, m_tlast on the pixel that
//   the last byte completes. Palette writes give no pixel; a partial pixel at
//   the last byte is dropped.
//   source_format is written over the apb port at address 0 while idle; a
//   write also discards any pixel in progress.
// Timing:
//   a completed pixel is registered in the queue and then in the result stage. One
//   input transaction per cycle is sustained while the queue has room; each pal4
//   byte needs two reads in the palette lookup unit, which has one ram read port.
//   A 4-entry queue sits between the byte gatherer and the lookup unit.
// Reset and stall:
//   rst clears the format to bgra32, the queue and the byte gatherer; the
//   palette holds garbage until written. When m_tready is low the result is
//   held and the queue fills, then s_tready drops.
`timescale 1ns / 1ps
module raster_to_bgra32_converter #(
  parameter int PALETTE_DEPTH = rtb_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // palette_index[7:0], palette_entry[39:8], raster_byte[47:40]
  input  logic        s_tuser,   // action[0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_bgra[31:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtb_pkg::*;

  logic    [2:0] source_format;
  logic          format_write;
  logic          push;
  rtb_op_t       push_op;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  rtb_op_t       head_op;

  assign pready       = 1'b1;
  assign format_write = psel && penable && pwrite && (paddr[2] == REG_SOURCE_FORMAT);
  assign prdata       = (paddr[2] == REG_SOURCE_FORMAT) ? {29'd0, source_format} : 32'd0;
  assign s_tready     = !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_BGRA32;
    end else if (format_write) begin
      source_format <= pwdata[2:0];
    end
  end

  rtb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .action       (s_tuser),
    .palette_index(s_tdata[7:0]),
    .palette_entry(s_tdata[39:8]),
    .raster_byte  (s_tdata[47:40]),
    .last_byte    (s_tlast),
    .source_format(source_format),
    .format_write (format_write),
    .push         (push),
    .push_op      (push_op)
  );

  rtb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_op   (head_op)
  );

  rtb_back #(
    .PaletteDepth(PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the raster to bgra32 converter
`timescale 1ns / 1ps
module tb;
  import rtb_pkg::*;

  localparam int     ITEMS_PER_PHASE = 50;
  localparam int     NUM_PHASES      = 14;
  localparam int     PRESSURE_PHASE  = 3;
  localparam int     QUIET_PHASE     = 5;
  localparam int     HOLD_CYCLES     = 300;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     DRAIN_LIMIT     = 5000;
  localparam longint LIMIT_NS        = 12_000_000;

  typedef struct packed {
    logic [31:0] bgra;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic        act;
    logic [7:0]  idx;
    logic [31:0] ent;
    logic [7:0]  rb;
    logic        last;
    logic        typed;
    logic [31:0] t_bgra;
    logic        t_last;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // palette_index[7:0], palette_entry[39:8], raster_byte[47:40]
  logic        s_tuser;   // action[0]
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // pixel_bgra[31:0]
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [31:0] palette_words [256];
  logic [23:0] gather;
  logic [1:0]  gather_pos;
  logic [2:0]  src_fmt;

  pixel_t pending_pixels [$];
  int     mismatches;
  bit     send_quiet;
  bit     recv_quiet;
  bit     hold_request;
  bit     hold_done;

  dir_row_t dir_rows [0:23] = '{
    '{FMT_BGRA32, ACT_RASTER,    8'h00, 32'h0,        8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_BGRA32, ACT_RASTER,    8'h00, 32'h0,        8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_BGRA32, ACT_RASTER,    8'h00, 32'h0,        8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_BGRA32, ACT_RASTER,    8'h00, 32'h0,        8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{FMT_RGBA32, ACT_RASTER,    8'h00, 32'h0,        8'h11, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGBA32, ACT_RASTER,    8'h00, 32'h0,        8'h22, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGBA32, ACT_RASTER,    8'h00, 32'h0,        8'h33, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGBA32, ACT_RASTER,    8'h00, 32'h0,        8'h44, 1'b0, 1'b0, 32'h0, 1'b0},
    // two bytes in progress, dropped by the next format write
    '{FMT_BGR32,  ACT_RASTER,    8'h00, 32'h0,        8'hAA, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_BGR32,  ACT_RASTER,    8'h00, 32'h0,        8'hBB, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGB32,  ACT_RASTER,    8'h00, 32'h0,        8'h01, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGB32,  ACT_RASTER,    8'h00, 32'h0,        8'h02, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGB32,  ACT_RASTER,    8'h00, 32'h0,        8'h03, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGB32,  ACT_RASTER,    8'h00, 32'h0,        8'h04, 1'b1, 1'b0, 32'h0, 1'b0},
    '{FMT_BGR24,  ACT_RASTER,    8'h00, 32'h0,        8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_BGR24,  ACT_RASTER,    8'h00, 32'h0,        8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_BGR24,  ACT_RASTER,    8'h00, 32'h0,        8'h00, 1'b1, 1'b1, 32'hFF000000, 1'b1},
    // partial pixel ended by the last byte gives nothing
    '{FMT_RGB24,  ACT_RASTER,    8'h00, 32'h0,        8'h01, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_RGB24,  ACT_RASTER,    8'h00, 32'h0,        8'h02, 1'b1, 1'b0, 32'h0, 1'b0},
    '{FMT_PAL8,   ACT_PAL_WRITE, 8'hFF, 32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_PAL8,   ACT_RASTER,    8'h00, 32'h0,        8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{FMT_PAL4,   ACT_PAL_WRITE, 8'h0F, 32'h12345678, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
    '{FMT_PAL4,   ACT_RASTER,    8'h00, 32'h0,        8'hF0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{FMT_PAL4,   ACT_RASTER,    8'h00, 32'h0,        8'h00, 1'b0, 1'b0, 32'h0, 1'b0}
  };

  raster_to_bgra32_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // palette words are r,g,b,a from the low byte up
  function automatic logic [31:0] palette_to_bgra(input logic [31:0] w);
    return {w[31:24], w[7:0], w[15:8], w[23:16]};
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic convert_item(input logic act, input logic [7:0] idx, input logic [31:0] ent,
                              input logic [7:0] rb, input logic last,
                              output int n, output pixel_t px0, output pixel_t px1);
    int need;
    logic [31:0] word;
    n   = 0;
    px0 = '0;
    px1 = '0;
    if (act == ACT_PAL_WRITE) begin
      palette_words[idx] = ent;
    end else if (src_fmt == FMT_PAL4) begin
      px0 = {palette_to_bgra(palette_words[{4'd0, rb[7:4]}]), 1'b0};
      px1 = {palette_to_bgra(palette_words[{4'd0, rb[3:0]}]), last};
      n   = 2;
      if (last) begin
        gather     = '0;
        gather_pos = '0;
      end
    end else if (src_fmt == FMT_PAL8) begin
      px0 = {palette_to_bgra(palette_words[rb]), last};
      n   = 1;
      if (last) begin
        gather     = '0;
        gather_pos = '0;
      end
    end else begin
      need = (src_fmt == FMT_BGR24 || src_fmt == FMT_RGB24) ? 3 : 4;
      if (int'(gather_pos) + 1 < need) begin
        gather[8*gather_pos +: 8] = rb;
        gather_pos = gather_pos + 2'd1;
        if (last) begin
          gather     = '0;
          gather_pos = '0;
        end
      end else begin
        case (src_fmt)
          FMT_BGR24: word = {ALPHA_OPAQUE, rb, gather[15:8], gather[7:0]};
          FMT_RGB24: word = {ALPHA_OPAQUE, gather[7:0], gather[15:8], rb};
          FMT_RGBA32, FMT_RGB32: word = {rb, gather[7:0], gather[15:8], gather[23:16]};
          default: word = {rb, gather[23:16], gather[15:8], gather[7:0]};
        endcase
        px0        = {word, last};
        n          = 1;
        gather     = '0;
        gather_pos = '0;
      end
    end
  endtask

  // offer one transaction, wait for it to be taken, then predict its pixels
  task automatic push_item(input logic act, input logic [7:0] idx, input logic [31:0] ent,
                           input logic [7:0] rb, input logic last,
                           input logic typed, input pixel_t typed_px);
    int gap;
    int n;
    pixel_t px0;
    pixel_t px1;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {rb, ent, idx};
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    convert_item(act, idx, ent, rb, last, n, px0, px1);
    if (typed) begin
      pending_pixels.push_back(typed_px);
    end else begin
      if (n > 0) pending_pixels.push_back(px0);
      if (n > 1) pending_pixels.push_back(px1);
    end
  endtask

  // stop offering, wait for every expected pixel, then let the pipe empty
  task automatic settle_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived, next expected %h last %b",
               $time, pending_pixels.size(), pending_pixels[0].bgra, pending_pixels[0].last);
      mismatches++;
      pending_pixels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input logic [2:0] f);
    logic [31:0] rd;
    settle_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(4 * int'(REG_SOURCE_FORMAT));
    pwdata  = {29'd0, f};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    src_fmt    = f;
    gather     = '0;
    gather_pos = '0;
    // read back through a second transaction
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[2:0] != f) begin
      $display("%0t: source_format readback, expected %h got %h", $time, f, rd[2:0]);
      mismatches++;
    end
  endtask

  // receiver side: random back-pressure plus one long hold
  initial begin
    int gap;
    m_tready  = 1'b0;
    hold_done = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_tready  = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        gap = pick_gap(recv_quiet);
        if (gap == 0) begin
          m_tready = 1'b1;
        end else begin
          m_tready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none got %h last %b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata !== want.bgra) begin
          $display("%0t: pixel_bgra mismatch, expected %h got %h", $time, want.bgra, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_pixel mismatch, expected %b got %b", $time, want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int cnt;
    int r;
    int bpp;
    int nbytes;
    bit with_last;
    logic [2:0] fmt;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = ACT_PAL_WRITE;
    s_tlast      = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    send_quiet   = 1'b0;
    recv_quiet   = 1'b0;
    hold_request = 1'b0;
    gather       = '0;
    gather_pos   = '0;
    src_fmt      = FMT_BGRA32;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // fill the whole palette so no lookup ever hits an unwritten entry
    for (int i = 0; i < 256; i++)
      push_item(ACT_PAL_WRITE, 8'(i), $urandom, 8'($urandom), 1'($urandom_range(0, 1)),
                1'b0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != src_fmt) set_format(dir_rows[i].fmt);
      push_item(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].ent, dir_rows[i].rb,
                dir_rows[i].last, dir_rows[i].typed, {dir_rows[i].t_bgra, dir_rows[i].t_last});
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) fmt = FMT_BGRA32;
      else if (ph == 1) fmt = FMT_RGB24;
      else if (ph == PRESSURE_PHASE) fmt = FMT_PAL4;
      else fmt = 3'($urandom_range(0, 7));
      set_format(fmt);
      send_quiet = (ph == PRESSURE_PHASE || ph == QUIET_PHASE);
      recv_quiet = (ph == QUIET_PHASE);
      if (ph == PRESSURE_PHASE) hold_request = 1'b1;
      bpp = (fmt == FMT_PAL4 || fmt == FMT_PAL8) ? 1 :
            (fmt == FMT_BGR24 || fmt == FMT_RGB24) ? 3 : 4;
      cnt = 0;
      while (cnt < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          push_item(ACT_PAL_WRITE, 8'($urandom), $urandom, 8'($urandom),
                    1'($urandom_range(0, 1)), 1'b0, '0);
          cnt++;
        end else begin
          // one image of whole pixels; some are cut short, some run on without tlast
          nbytes = bpp * $urandom_range(1, 6);
          if (r < 18 && bpp > 1) nbytes -= $urandom_range(1, bpp - 1);
          with_last = (r < 94);
          for (int k = 0; k < nbytes; k++)
            push_item(ACT_RASTER, 8'($urandom), $urandom, 8'($urandom),
                      with_last && (k == nbytes - 1), 1'b0, '0);
          cnt += nbytes;
        end
      end
    end

    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    settle_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rtb_pkg.sv
rtl/core/rtb_ram.sv
rtl/core/rtb_front.sv
rtl/core/rtb_queue.sv
rtl/core/rtb_back.sv
rtl/core/raster_to_bgra32_converter.sv
tb/tb.sv
